### design/lrbm_pkg.sv
// lrbm_pkg: shared constants, codes and types of the margin ring buffer
// no dependencies; used by the interfaces and the top module
`default_nettype none

package lrbm_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int SIZE_W      = 13;
    localparam int MARG_W      = 12;
    localparam int LEN_W       = 13;
    localparam int OP_W        = 3;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(STORE_DEPTH);
    localparam logic [MARG_W-1:0] MARG_RESET = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_SIZE = CFG_IDX_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 3'd0,
        OP_GET    = 3'd1,
        OP_READ   = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDATA,
        S_COPY,
        S_GFIN
    } t_state;

    typedef struct packed {
        logic              accepted;
        logic [LEN_W-1:0]  block_length;
        logic [PTR_W-1:0]  block_start;
        logic [BYTE_W-1:0] read_byte;
        logic              error_flag;
        logic [LEN_W-1:0]  bytes_available;
    } t_result;

endpackage

`default_nettype wire

### design/lrbm_if.sv
// lrbm_cmd_if / lrbm_rsp_if: valid/ready channels for command and result words
// depends on lrbm_pkg
`default_nettype none

interface lrbm_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [lrbm_pkg::OP_W-1:0]     operation;
    logic [lrbm_pkg::BYTE_W-1:0]   data_byte;
    logic [lrbm_pkg::LEN_W-1:0]    amount;

    modport source (output valid, output operation, output data_byte, output amount,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input amount,
                    output ready);
endinterface

interface lrbm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic [lrbm_pkg::LEN_W-1:0]    block_length;
    logic [lrbm_pkg::PTR_W-1:0]    block_start;
    logic [lrbm_pkg::BYTE_W-1:0]   read_byte;
    logic                          error_flag;
    logic [lrbm_pkg::LEN_W-1:0]    bytes_available;

    modport source (output valid, output accepted, output block_length, output block_start,
                    output read_byte, output error_flag, output bytes_available,
                    input ready);
    modport sink   (input valid, input accepted, input block_length, input block_start,
                    input read_byte, input error_flag, input bytes_available,
                    output ready);
endinterface

`default_nettype wire

### design/lrbm_ram.sv
// lrbm_ram: generic simple dual-port RAM, one write port, one registered read port
// no dependencies
`default_nettype none

module lrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/linear_ring_buffer_with_margin_top.sv
// linear_ring_buffer_with_margin_top: byte ring buffer whose pointers wrap to a margin
// depends on lrbm_pkg, lrbm_if (lrbm_cmd_if, lrbm_rsp_if) and lrbm_ram
`default_nettype none

// Byte ring buffer held in one dual-port byte store. Pointers wrap back to margin_size
// instead of zero so a get can always hand out a contiguous run of at least margin_size
// bytes. Put, delete, clear, unknown codes, a read outside the granted block and every
// command under an invalid configuration finish in S_IDLE; a read inside the block ends
// in S_RDATA, as the store read port is registered. A get ends in S_IDLE, or passes
// through S_COPY and S_GFIN when the tail fragment (fewer than margin_size bytes) has
// to be moved to the front first: the move goes one byte per cycle through the read
// and write ports of the store. Results leave through a two-word output stage, so a new
// command is taken while an earlier result still waits downstream. Config writes restart
// both pointers at margin_size and are meant to happen only while the block is idle.
module linear_ring_buffer_with_margin_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lrbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lrbm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lrbm_cmd_if.sink                          i_cmd,
    lrbm_rsp_if.source                        o_rsp
);

    localparam int PW = lrbm_pkg::PTR_W;
    localparam int SW = lrbm_pkg::SIZE_W;
    localparam int MW = lrbm_pkg::MARG_W;
    localparam int LW = lrbm_pkg::LEN_W;
    localparam int BW = lrbm_pkg::BYTE_W;

    // configuration and pointers
    logic [SW-1:0] r_size;
    logic [MW-1:0] r_marg;
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [LW-1:0] r_granted, n_granted;

    lrbm_pkg::t_state r_state, n_state;

    // fragment move
    logic [PW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_frag, n_frag;
    logic [PW-1:0] r_dst, n_dst;
    logic          r_wv, n_wv;
    logic [PW-1:0] r_wa, n_wa;

    // result stage
    lrbm_pkg::t_result res;
    logic              res_we;
    lrbm_pkg::t_result r_pend;
    logic              r_pend_valid;
    lrbm_pkg::t_result r_out;
    logic              r_out_valid;
    logic              pend_move;

    // store
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [BW-1:0] ram_wdata;
    logic [PW-1:0] ram_raddr;
    logic [BW-1:0] ram_rdata;

    logic              cfg_ok;
    logic              acc_in;
    lrbm_pkg::t_op     op;
    logic              read_hit;
    logic              need_copy;
    logic signed [14:0] rest_put, d_put, room;
    logic signed [14:0] rest_get, rest_eff, cont, get_cont;
    logic              get_ok;
    logic [LW-1:0]     del_cnt;
    logic              del_over;
    logic [PW+1:0]     del_tail;

    // bytes between tail and head, margin area skipped on wrap; not clamped
    function automatic logic signed [14:0] span(input logic [PW-1:0] head,
                                                input logic [PW-1:0] tail,
                                                input logic [SW-1:0] size,
                                                input logic [MW-1:0] marg);
        logic signed [14:0] d;
        d = $signed(15'(head)) - $signed(15'(tail));
        if (d < 0) begin
            span = $signed(15'(size)) + d - $signed(15'(marg));
        end else begin
            span = d;
        end
    endfunction

    function automatic logic [LW-1:0] held(input logic [PW-1:0] head,
                                           input logic [PW-1:0] tail,
                                           input logic [SW-1:0] size,
                                           input logic [MW-1:0] marg);
        logic signed [14:0] s;
        s = span(head, tail, size, marg);
        held = (s > 0) ? s[LW-1:0] : '0;
    endfunction

    assign cfg_ok = (r_size >= SW'(2)) && (r_size <= lrbm_pkg::SIZE_RESET)
                    && (SW'(r_marg) <= (r_size >> 1));

    assign pend_move   = r_pend_valid && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = (r_state == lrbm_pkg::S_IDLE) && (!r_pend_valid || pend_move);
    assign acc_in      = i_cmd.valid && i_cmd.ready;
    assign op          = lrbm_pkg::t_op'(i_cmd.operation);

    // put: free room
    assign rest_put = $signed(15'(r_size)) - $signed(15'(r_wp));
    assign d_put    = $signed(15'(r_rp)) - $signed(15'(r_wp));
    always_comb begin
        if (15'(r_rp) < 15'(r_marg)) begin
            room = rest_put;
        end else if (d_put > 0) begin
            room = d_put;
        end else begin
            room = $signed(15'(r_size)) + d_put - $signed(15'(r_marg));
        end
    end

    // get: contiguous run from the tail
    assign rest_get  = $signed(15'(r_size)) - $signed(15'(r_rp));
    assign need_copy = (rest_get < $signed(15'(r_marg))) && (r_wp < r_rp);
    assign rest_eff  = (r_state == lrbm_pkg::S_GFIN)
                       ? ($signed(15'(r_wp)) - $signed(15'(r_rp))) : rest_get;
    assign cont      = span(r_wp, r_rp, r_size, r_marg);
    assign get_cont  = (cont > rest_eff) ? rest_eff : cont;
    assign get_ok    = get_cont >= $signed(15'(r_marg));

    assign read_hit = i_cmd.amount < r_granted;

    assign del_over = i_cmd.amount > r_granted;
    assign del_cnt  = del_over ? r_granted : i_cmd.amount;
    assign del_tail = (PW+2)'(r_rp) + (PW+2)'(del_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrbm_pkg::S_IDLE: begin
                if (acc_in && cfg_ok) begin
                    if (op == lrbm_pkg::OP_GET && need_copy) begin
                        n_state = lrbm_pkg::S_COPY;
                    end else if (op == lrbm_pkg::OP_READ && read_hit) begin
                        n_state = lrbm_pkg::S_RDATA;
                    end
                end
            end
            lrbm_pkg::S_COPY: begin
                if (r_cnt == r_frag) begin
                    n_state = lrbm_pkg::S_GFIN;
                end
            end
            lrbm_pkg::S_RDATA: n_state = lrbm_pkg::S_IDLE;
            lrbm_pkg::S_GFIN:  n_state = lrbm_pkg::S_IDLE;
            default:           n_state = lrbm_pkg::S_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_granted = r_granted;
        n_cnt     = r_cnt;
        n_frag    = r_frag;
        n_dst     = r_dst;
        n_wv      = 1'b0;
        n_wa      = r_wa;
        res       = '0;
        res_we    = 1'b0;
        ram_we    = r_wv;
        ram_waddr = r_wa;
        ram_wdata = ram_rdata;
        ram_raddr = r_rp + r_cnt;

        unique case (r_state)
            lrbm_pkg::S_IDLE: begin
                if (acc_in) begin
                    if (!cfg_ok) begin
                        res_we         = 1'b1;
                        res.error_flag = 1'b1;
                    end else begin
                        unique case (op)
                            lrbm_pkg::OP_PUT: begin
                                res_we = 1'b1;
                                if (room > 1) begin
                                    ram_we       = 1'b1;
                                    ram_waddr    = r_wp;
                                    ram_wdata    = i_cmd.data_byte;
                                    n_wp         = (rest_put <= 1) ? PW'(r_marg) : r_wp + 1'b1;
                                    res.accepted = 1'b1;
                                end
                            end
                            lrbm_pkg::OP_GET: begin
                                if (need_copy) begin
                                    n_cnt  = '0;
                                    n_frag = rest_get[PW-1:0];
                                    n_dst  = PW'(r_marg) - rest_get[PW-1:0];
                                end else begin
                                    res_we          = 1'b1;
                                    res.block_start = r_rp;
                                    if (get_ok) begin
                                        n_granted        = get_cont[LW-1:0];
                                        res.accepted     = 1'b1;
                                        res.block_length = get_cont[LW-1:0];
                                    end
                                end
                            end
                            lrbm_pkg::OP_READ: begin
                                if (read_hit) begin
                                    ram_raddr = r_rp + i_cmd.amount[PW-1:0];
                                end else begin
                                    res_we         = 1'b1;
                                    res.error_flag = 1'b1;
                                end
                            end
                            lrbm_pkg::OP_DELETE: begin
                                res_we         = 1'b1;
                                res.error_flag = del_over;
                                if (del_cnt != '0) begin
                                    n_rp = (del_tail >= (PW+2)'(r_size))
                                           ? PW'(r_marg) : del_tail[PW-1:0];
                                    n_granted        = r_granted - del_cnt;
                                    res.block_length = del_cnt;
                                end
                            end
                            lrbm_pkg::OP_CLEAR: begin
                                res_we    = 1'b1;
                                n_rp      = r_wp;
                                n_granted = '0;
                            end
                            default: res_we = 1'b1;
                        endcase
                        res.bytes_available = held(n_wp, n_rp, r_size, r_marg);
                    end
                end
            end
            lrbm_pkg::S_COPY: begin
                // read one byte per cycle, write it back in the next cycle
                if (r_cnt != r_frag) begin
                    ram_raddr = r_rp + r_cnt;
                    n_cnt     = r_cnt + 1'b1;
                    n_wv      = 1'b1;
                    n_wa      = r_dst + r_cnt;
                end else begin
                    n_rp = r_dst;
                end
            end
            lrbm_pkg::S_RDATA: begin
                res_we              = 1'b1;
                res.read_byte       = ram_rdata;
                res.bytes_available = held(r_wp, r_rp, r_size, r_marg);
            end
            lrbm_pkg::S_GFIN: begin
                res_we          = 1'b1;
                res.block_start = r_rp;
                if (get_ok) begin
                    n_granted        = get_cont[LW-1:0];
                    res.accepted     = 1'b1;
                    res.block_length = get_cont[LW-1:0];
                end
                res.bytes_available = held(r_wp, r_rp, r_size, r_marg);
            end
            default: res_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lrbm_pkg::S_IDLE;
            r_size       <= lrbm_pkg::SIZE_RESET;
            r_marg       <= lrbm_pkg::MARG_RESET;
            r_wp         <= PW'(lrbm_pkg::MARG_RESET);
            r_rp         <= PW'(lrbm_pkg::MARG_RESET);
            r_granted    <= '0;
            r_wv         <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wv    <= n_wv;
            if (i_cfg_we && (i_cfg_index == lrbm_pkg::CFG_BUFFER_SIZE)) begin
                r_size    <= i_cfg_data[SW-1:0];
                r_wp      <= PW'(r_marg);
                r_rp      <= PW'(r_marg);
                r_granted <= '0;
            end else if (i_cfg_we && (i_cfg_index == lrbm_pkg::CFG_MARGIN_SIZE)) begin
                r_marg    <= i_cfg_data[MW-1:0];
                r_wp      <= PW'(i_cfg_data[MW-1:0]);
                r_rp      <= PW'(i_cfg_data[MW-1:0]);
                r_granted <= '0;
            end else begin
                r_wp      <= n_wp;
                r_rp      <= n_rp;
                r_granted <= n_granted;
            end

            if (res_we) begin
                r_pend_valid <= 1'b1;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end

            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_frag <= n_frag;
        r_dst  <= n_dst;
        r_wa   <= n_wa;
        if (res_we) begin
            r_pend <= res;
        end
        if (pend_move) begin
            r_out <= r_pend;
        end
    end

    lrbm_ram #(
        .WIDTH (BW),
        .DEPTH (lrbm_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.accepted        = r_out.accepted;
    assign o_rsp.block_length    = r_out.block_length;
    assign o_rsp.block_start     = r_out.block_start;
    assign o_rsp.read_byte       = r_out.read_byte;
    assign o_rsp.error_flag      = r_out.error_flag;
    assign o_rsp.bytes_available = r_out.bytes_available;

`ifndef SYNTHESIS
    // multi-cycle commands finish into a free result slot
    a_pend_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrbm_pkg::S_RDATA || r_state == lrbm_pkg::S_GFIN) |-> !r_pend_valid)
        else $error("result slot busy when a multi-cycle command finishes");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_ok |-> (SW'(r_wp) < r_size) && (SW'(r_rp) < r_size))
        else $error("pointer outside the active store");

    a_granted_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_ok |-> (r_granted <= r_size))
        else $error("granted count above buffer size");

    a_copy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrbm_pkg::S_COPY) |-> (r_cnt <= r_frag))
        else $error("fragment move ran past its length");

    a_copy_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrbm_pkg::S_COPY && r_cnt != r_frag) |=> r_wv)
        else $error("fragment byte read without write-back");
`endif

endmodule

`default_nettype wire
